// ===== rtl/forwarder_timer_suppression_table_assert.svh =====
// Assertion macros used by the checker.
`ifndef FORWARDER_TIMER_SUPPRESSION_TABLE_ASSERT_SVH
`define FORWARDER_TIMER_SUPPRESSION_TABLE_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define FWTS_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("fwts assertion failed");

// Next-cycle implication, held off during reset.
`define FWTS_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("fwts assertion failed");

`endif

// ===== rtl/fwts_pkg.sv =====
package fwts_pkg;

  localparam int ID_W        = 32;
  localparam int ADDR_W      = 48;
  localparam int UNIT_W      = 16;
  localparam int REM_W       = 18;
  localparam int COUNT_W     = 3;
  localparam int OP_W        = 2;
  localparam int ADDR_FIELDS = 4;

  localparam int DEF_TABLE_DEPTH    = 8;
  localparam int DEF_MAX_CANDIDATES = 4;

  localparam logic [UNIT_W-1:0] WAIT_UNIT_RST  = UNIT_W'(10);
  localparam logic [ADDR_W-1:0] LOCAL_ADDR_RST = '0;

  // operation codes
  localparam logic [OP_W-1:0] OP_RECEIVE  = 2'd0;
  localparam logic [OP_W-1:0] OP_OVERHEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK     = 2'd2;

  // result event codes
  localparam logic EV_FORWARD = 1'b0;
  localparam logic EV_DROP    = 1'b1;

  // configuration register indexes
  localparam logic CFG_WAIT_UNIT  = 1'b0;
  localparam logic CFG_LOCAL_ADDR = 1'b1;

  // broadcast command to the lanes; per-lane select comes separately
  typedef struct packed {
    logic              load;
    logic              restart;
    logic              cancel;
    logic              tick;
    logic [ID_W-1:0]   id;
    logic [REM_W-1:0]  wait_ticks;
  } lane_cmd_t;

  typedef struct packed {
    logic match;
    logic free;
    logic expire;
  } lane_stat_t;

endpackage

// ===== rtl/forwarder_timer_suppression_table.sv =====
// Channel  Signals                                      Direction
// in       in_valid/in_ready, operation, pkt_id,        sink
//          candidate_count, candidate_0..candidate_3
// out      out_valid/out_ready, event_res, result_id,   source
//          last
// cfg      cfg_valid/cfg_ready, cfg_index, cfg_data     sink
//
// Receive and overheard items pass through capture, lane compare and apply.
// A tick takes the same steps, then its expiring entries are emitted from the
// one output register in ascending slot order.
// A drop or expiry waits while the output register is held by out_ready low.
// Reset clears all entry valid bits at once; no clearing pass.
module forwarder_timer_suppression_table import fwts_pkg::*; #(
  parameter int TABLE_DEPTH    = DEF_TABLE_DEPTH,
  parameter int MAX_CANDIDATES = DEF_MAX_CANDIDATES
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     operation,
  input  logic [ID_W-1:0]     pkt_id,
  input  logic [COUNT_W-1:0]  candidate_count,
  input  logic [ADDR_W-1:0]   candidate_0,
  input  logic [ADDR_W-1:0]   candidate_1,
  input  logic [ADDR_W-1:0]   candidate_2,
  input  logic [ADDR_W-1:0]   candidate_3,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                event_res,
  output logic [ID_W-1:0]     result_id,
  output logic                last,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [ADDR_W-1:0]   cfg_data
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_LOOK  = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]             state;
  logic [OP_W-1:0]        op_r;
  logic [ID_W-1:0]        id_r;
  logic [COUNT_W-1:0]     count_r;
  logic [ADDR_W-1:0]      cand_r [ADDR_FIELDS];
  logic [UNIT_W-1:0]      wait_unit;
  logic [ADDR_W-1:0]      local_address;
  logic [TABLE_DEPTH-1:0] match_r;
  logic [TABLE_DEPTH-1:0] free_r;
  logic [TABLE_DEPTH-1:0] pend;

  logic [REM_W-1:0]       wait_ticks;
  lane_cmd_t              cmd;
  logic [TABLE_DEPTH-1:0] sel_vec;
  lane_stat_t             stat [TABLE_DEPTH];
  logic [ID_W-1:0]        lane_packet [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] match_vec;
  logic [TABLE_DEPTH-1:0] free_vec;
  logic [TABLE_DEPTH-1:0] expire_vec;

  logic [IW-1:0] m_idx, f_idx, p_idx;
  logic          m_found, f_found, p_found;
  logic          m_single, f_single, p_single;

  logic          out_free;
  logic          load_out;
  logic          out_ev;
  logic [ID_W-1:0] out_id;
  logic          out_last;

  assign in_ready  = state == ST_IDLE;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  fwts_wait #(.MAX_CANDIDATES(MAX_CANDIDATES)) u_wait (
    .clk             (clk),
    .candidate_count (count_r),
    .cand            (cand_r),
    .local_address   (local_address),
    .wait_unit       (wait_unit),
    .wait_ticks      (wait_ticks)
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_lane
    fwts_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .cmd    (cmd),
      .sel    (sel_vec[i]),
      .cmp_id (id_r),
      .stat   (stat[i]),
      .packet (lane_packet[i])
    );
    assign match_vec[i]  = stat[i].match;
    assign free_vec[i]   = stat[i].free;
    assign expire_vec[i] = stat[i].expire;
  end

  fwts_pick #(.N(TABLE_DEPTH), .IW(IW)) u_pick_match (
    .vec (match_r), .idx (m_idx), .found (m_found), .single (m_single)
  );
  fwts_pick #(.N(TABLE_DEPTH), .IW(IW)) u_pick_free (
    .vec (free_r), .idx (f_idx), .found (f_found), .single (f_single)
  );
  fwts_pick #(.N(TABLE_DEPTH), .IW(IW)) u_pick_pend (
    .vec (pend), .idx (p_idx), .found (p_found), .single (p_single)
  );

  // lane commands and result loads
  always_comb begin
    cmd            = '0;
    cmd.id         = id_r;
    cmd.wait_ticks = wait_ticks;
    sel_vec        = '0;
    load_out       = 1'b0;
    out_ev         = EV_FORWARD;
    out_id         = lane_packet[p_idx];
    out_last       = p_single;
    case (state)
      ST_APPLY: begin
        case (op_r)
          OP_RECEIVE: begin
            if (m_found) begin
              cmd.restart    = 1'b1;
              sel_vec[m_idx] = 1'b1;
            end else if (f_found) begin
              cmd.load       = 1'b1;
              sel_vec[f_idx] = 1'b1;
            end else begin
              load_out = out_free;
              out_ev   = EV_DROP;
              out_id   = id_r;
              out_last = 1'b1;
            end
          end
          OP_OVERHEAR: begin
            if (m_found) begin
              cmd.cancel     = 1'b1;
              sel_vec[m_idx] = 1'b1;
            end
          end
          OP_TICK: begin
            cmd.tick = 1'b1;
          end
          default: begin
          end
        endcase
      end
      ST_EMIT: begin
        load_out = out_free && p_found;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      out_valid     <= 1'b0;
      pend          <= '0;
      wait_unit     <= WAIT_UNIT_RST;
      local_address <= LOCAL_ADDR_RST;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_WAIT_UNIT:  wait_unit     <= cfg_data[UNIT_W-1:0];
          CFG_LOCAL_ADDR: local_address <= cfg_data;
          default: begin
          end
        endcase
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          state <= ST_APPLY;
        end
        ST_APPLY: begin
          if (op_r == OP_TICK) begin
            // expiries are judged before the countdown applies
            pend  <= expire_vec;
            state <= (|expire_vec) ? ST_EMIT : ST_IDLE;
          end else if (op_r == OP_RECEIVE && !m_found && !f_found) begin
            if (out_free) begin
              state <= ST_IDLE;
            end
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (load_out) begin
            pend[p_idx] <= 1'b0;
            if (p_single) begin
              state <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // item capture, lane snapshot and result register loads
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      op_r      <= operation;
      id_r      <= pkt_id;
      count_r   <= candidate_count;
      cand_r[0] <= candidate_0;
      cand_r[1] <= candidate_1;
      cand_r[2] <= candidate_2;
      cand_r[3] <= candidate_3;
    end
    if (state == ST_LOOK) begin
      match_r <= match_vec;
      free_r  <= free_vec;
    end
    if (load_out) begin
      event_res <= out_ev;
      result_id <= out_id;
      last      <= out_last;
    end
  end

endmodule

// ===== rtl/fwts_lane.sv =====
module fwts_lane import fwts_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  lane_cmd_t        cmd,
  input  logic             sel,
  input  logic [ID_W-1:0]  cmp_id,
  output lane_stat_t       stat,
  output logic [ID_W-1:0]  packet
);

  logic             valid;
  logic [REM_W-1:0] remaining;
  logic             at_end;

  assign at_end = remaining <= REM_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (sel && cmd.load) begin
      valid <= 1'b1;
    end else if (sel && cmd.cancel) begin
      valid <= 1'b0;
    end else if (cmd.tick && valid && at_end) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sel && cmd.load) begin
      packet <= cmd.id;
    end
    if (sel && (cmd.load || cmd.restart)) begin
      remaining <= cmd.wait_ticks;
    end else if (cmd.tick && valid) begin
      remaining <= at_end ? '0 : remaining - REM_W'(1);
    end
  end

  assign stat.match  = valid && (packet == cmp_id);
  assign stat.free   = !valid;
  assign stat.expire = valid && at_end;

endmodule

// ===== rtl/fwts_wait.sv =====
module fwts_wait import fwts_pkg::*; #(
  parameter int MAX_CANDIDATES = DEF_MAX_CANDIDATES
) (
  input  logic                clk,
  input  logic [COUNT_W-1:0]  candidate_count,
  input  logic [ADDR_W-1:0]   cand [ADDR_FIELDS],
  input  logic [ADDR_W-1:0]   local_address,
  input  logic [UNIT_W-1:0]   wait_unit,
  output logic [REM_W-1:0]    wait_ticks
);

  localparam int LIMIT  = (MAX_CANDIDATES < ADDR_FIELDS) ? MAX_CANDIDATES : ADDR_FIELDS;
  localparam int RANK_W = $clog2(LIMIT + 1);
  localparam int PROD_W = UNIT_W + RANK_W;

  logic [RANK_W-1:0] rank;
  logic              hit;
  logic [PROD_W-1:0] prod;
  logic              over;

  // first matching slot wins; slots past the count never match
  always_comb begin
    rank = '0;
    hit  = 1'b0;
    for (int s = 0; s < LIMIT; s++) begin
      if (!hit && (COUNT_W'(s) < candidate_count) && (cand[s] == local_address)) begin
        hit  = 1'b1;
        rank = RANK_W'(s + 1);
      end
    end
  end

  assign prod = PROD_W'(wait_unit) * PROD_W'(rank);
  assign over = |(prod >> REM_W);

  always_ff @(posedge clk) begin
    wait_ticks <= over ? {REM_W{1'b1}} : REM_W'(prod);
  end

endmodule

// ===== rtl/fwts_pick.sv =====
module fwts_pick #(
  parameter int N  = 8,
  parameter int IW = (N > 1) ? $clog2(N) : 1
) (
  input  logic [N-1:0]  vec,
  output logic [IW-1:0] idx,
  output logic          found,
  output logic          single
);

  // lowest set bit
  always_comb begin
    idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (vec[i]) begin
        idx = IW'(i);
      end
    end
  end

  assign found  = |vec;
  assign single = (vec & (vec - N'(1))) == '0;

endmodule

// ===== rtl/fwts_checker.sv =====
`include "forwarder_timer_suppression_table_assert.svh"

module fwts_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        event_res,
  input logic [31:0] result_id,
  input logic        last
);

  `FWTS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(result_id) && $stable(event_res) && $stable(last))

  // a drop is always the only result of its item
  `FWTS_ASSERT_NOW(a_drop_last, clk, rst, out_valid && event_res, last)

  // no new item while a burst of expiries is still going out
  `FWTS_ASSERT_NOW(a_burst_busy, clk, rst, out_valid && !last, !in_ready)

  // an accepted item keeps the block busy and shows no result in the next cycle
  `FWTS_ASSERT_NEXT(a_accept_busy, clk, rst, in_valid && in_ready, !in_ready && !$rose(out_valid))

endmodule

bind forwarder_timer_suppression_table fwts_checker u_fwts_checker (.*);
